>>> sv/mtfp_pkg.sv
// ----------------------------------------------------------------------------
// mtfp_pkg
// Shared types and constants for the motor telemetry frame parser.
// ----------------------------------------------------------------------------
package mtfp_pkg;

   localparam logic [7:0] HDR_FIRST  = 8'h68;
   localparam logic [7:0] HDR_SECOND = 8'h24;
   localparam logic [7:0] NEG_SIGN   = 8'h00;

   localparam int FRAME_LEN = 23;
   localparam int SUM_LEN   = 22;
   localparam int INDEX_W   = 5;

   localparam int COUNT_W = 32;
   localparam int SMALL_W = 17;

   typedef struct packed {
      logic        [COUNT_W-1:0] left_count;
      logic        [COUNT_W-1:0] right_count;
      logic signed [SMALL_W-1:0] left_velocity;
      logic signed [SMALL_W-1:0] right_velocity;
      logic signed [SMALL_W-1:0] left_motor_current;
      logic signed [SMALL_W-1:0] right_motor_current;
   } frame_type;

endpackage

>>> sv/mtfp_front.sv
// ----------------------------------------------------------------------------
// mtfp_front
// Byte parser: hunts for the header, collects the payload, checks the sum
// and hands a decoded frame to the queue.
// ----------------------------------------------------------------------------
module mtfp_front
   import mtfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        byte_valid,
   input  logic [7:0]  rx_byte,
   output logic        frame_push,
   output frame_type   frame
);

   typedef enum logic [2:0] {
      PH_HUNT = 3'b001,
      PH_HDR  = 3'b010,
      PH_DATA = 3'b100
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [INDEX_W-1:0]   payload_index_ff, payload_index_in;
   logic [7:0]           running_sum_ff, running_sum_in;
   logic [7:0]           store_ff [SUM_LEN];
   logic                 store_we;

   function automatic logic [COUNT_W-1:0] count_at(input logic [7:0] s,
                                                   input logic [7:0] b3,
                                                   input logic [7:0] b2,
                                                   input logic [7:0] b1,
                                                   input logic [7:0] b0);
      logic [COUNT_W-1:0] mag;
      mag = {b3, b2, b1, b0};
      return (s == NEG_SIGN) ? (COUNT_W'(0) - mag) : mag;
   endfunction

   function automatic logic signed [SMALL_W-1:0] small_at(input logic [7:0] s,
                                                          input logic [7:0] b1,
                                                          input logic [7:0] b0);
      logic [SMALL_W-1:0] mag;
      mag = {1'b0, b1, b0};
      return (s == NEG_SIGN) ? (SMALL_W'(0) - mag) : mag;
   endfunction

   always_comb begin
      phase_in         = phase_ff;
      payload_index_in = payload_index_ff;
      running_sum_in   = running_sum_ff;
      store_we         = 1'b0;
      frame_push       = 1'b0;
      if (byte_valid) begin
         case (phase_ff)
            PH_HDR: begin
               phase_in         = (rx_byte == HDR_SECOND) ? PH_DATA : PH_HUNT;
               payload_index_in = '0;
               running_sum_in   = '0;
            end
            PH_DATA: begin
               if (payload_index_ff < INDEX_W'(SUM_LEN)) begin
                  store_we         = 1'b1;
                  running_sum_in   = running_sum_ff + rx_byte;
                  payload_index_in = payload_index_ff + 1'b1;
               end else begin
                  phase_in         = PH_HUNT;
                  payload_index_in = '0;
                  running_sum_in   = '0;
                  frame_push       = (running_sum_ff == rx_byte);
               end
            end
            default: begin
               phase_in = (rx_byte == HDR_FIRST) ? PH_HDR : PH_HUNT;
            end
         endcase
      end
   end

   always_comb begin
      frame.left_count          = count_at(store_ff[0], store_ff[1], store_ff[2],
                                           store_ff[3], store_ff[4]);
      frame.right_count         = count_at(store_ff[5], store_ff[6], store_ff[7],
                                           store_ff[8], store_ff[9]);
      frame.left_velocity       = small_at(store_ff[10], store_ff[11], store_ff[12]);
      frame.right_velocity      = small_at(store_ff[13], store_ff[14], store_ff[15]);
      frame.left_motor_current  = small_at(store_ff[16], store_ff[17], store_ff[18]);
      frame.right_motor_current = small_at(store_ff[19], store_ff[20], store_ff[21]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HUNT;
         payload_index_ff <= '0;
         running_sum_ff   <= '0;
      end else begin
         phase_ff         <= phase_in;
         payload_index_ff <= payload_index_in;
         running_sum_ff   <= running_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[payload_index_ff] <= rx_byte;
      end
   end

endmodule

>>> sv/mtfp_queue.sv
// ----------------------------------------------------------------------------
// mtfp_queue
// Short frame queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module mtfp_queue
   import mtfp_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  frame_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      empty,
   output frame_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   frame_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/mtfp_back.sv
// ----------------------------------------------------------------------------
// mtfp_back
// Output stage: captures zero offsets, forms positions and holds the
// result register for the receiver.
// ----------------------------------------------------------------------------
module mtfp_back
   import mtfp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       queue_empty,
   input  frame_type                  queue_data,
   output logic                       queue_pop,
   input  logic                       rsp_pop,
   output logic                       rsp_empty,
   output logic signed [COUNT_W-1:0]  left_position,
   output logic signed [COUNT_W-1:0]  right_position,
   output logic signed [SMALL_W-1:0]  left_velocity,
   output logic signed [SMALL_W-1:0]  right_velocity,
   output logic signed [SMALL_W-1:0]  left_motor_current,
   output logic signed [SMALL_W-1:0]  right_motor_current
);

   logic               valid_ff, valid_in;
   logic [COUNT_W-1:0] left_offset_ff, left_offset_in;
   logic [COUNT_W-1:0] right_offset_ff, right_offset_in;
   logic               capture;

   assign queue_pop = !queue_empty && (!valid_ff || rsp_pop);
   assign capture   = (left_offset_ff == '0) && (right_offset_ff == '0);
   assign valid_in  = queue_pop || (valid_ff && !rsp_pop);
   assign rsp_empty = !valid_ff;

   always_comb begin
      left_offset_in  = left_offset_ff;
      right_offset_in = right_offset_ff;
      if (queue_pop && capture) begin
         left_offset_in  = queue_data.left_count;
         right_offset_in = queue_data.right_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= 1'b0;
         left_offset_ff  <= '0;
         right_offset_ff <= '0;
      end else begin
         valid_ff        <= valid_in;
         left_offset_ff  <= left_offset_in;
         right_offset_ff <= right_offset_in;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         left_position       <= queue_data.left_count - left_offset_in;
         right_position      <= queue_data.right_count - right_offset_in;
         left_velocity       <= queue_data.left_velocity;
         right_velocity      <= queue_data.right_velocity;
         left_motor_current  <= queue_data.left_motor_current;
         right_motor_current <= queue_data.right_motor_current;
      end
   end

endmodule

>>> sv/motor_telemetry_frame_parser.sv
// ----------------------------------------------------------------------------
// motor_telemetry_frame_parser
// Parses motor controller telemetry frames from a received byte stream.
// ----------------------------------------------------------------------------
// Request side: push one received byte on req_rx_byte; it is taken when
// req_push is high and req_full is low. One byte is taken every cycle while req_full is low.
// Bytes are matched against the 0x68 0x24 header, 23 payload bytes follow,
// and the last one must equal the 8-bit sum of the first 22.
// Result side: one result per good frame. While rsp_empty is low the oldest
// result sits on the rsp_ ports; it is taken when rsp_pop is high.
// After the checksum byte is taken, the frame is written to the frame queue
// and then loaded into the result register, provided that register is free.
// Throughput: one byte per cycle while req_full is low, set by the parser step.
// A stalled receiver holds the result register; further frames wait in the
// frame queue of QUEUE_DEPTH entries, and req_full rises when it is full.
// Reset returns the parser to hunting, clears the zero offsets and empties
// the queue and the result register.
// ----------------------------------------------------------------------------
module motor_telemetry_frame_parser
   import mtfp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [7:0]                 req_rx_byte,
   input  logic                       rsp_pop,
   output logic                       rsp_empty,
   output logic signed [COUNT_W-1:0]  rsp_left_position,
   output logic signed [COUNT_W-1:0]  rsp_right_position,
   output logic signed [SMALL_W-1:0]  rsp_left_velocity,
   output logic signed [SMALL_W-1:0]  rsp_right_velocity,
   output logic signed [SMALL_W-1:0]  rsp_left_motor_current,
   output logic signed [SMALL_W-1:0]  rsp_right_motor_current
);

   logic      byte_valid;
   logic      frame_push;
   frame_type frame;
   logic      queue_empty;
   logic      queue_pop;
   frame_type queue_data;

   assign byte_valid = req_push && !req_full;

   mtfp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .rx_byte    (req_rx_byte),
      .frame_push (frame_push),
      .frame      (frame)
   );

   mtfp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (frame_push),
      .push_data (frame),
      .full      (req_full),
      .pop       (queue_pop),
      .empty     (queue_empty),
      .pop_data  (queue_data)
   );

   mtfp_back u_back (
      .clock               (clock),
      .reset               (reset),
      .queue_empty         (queue_empty),
      .queue_data          (queue_data),
      .queue_pop           (queue_pop),
      .rsp_pop             (rsp_pop),
      .rsp_empty           (rsp_empty),
      .left_position       (rsp_left_position),
      .right_position      (rsp_right_position),
      .left_velocity       (rsp_left_velocity),
      .right_velocity      (rsp_right_velocity),
      .left_motor_current  (rsp_left_motor_current),
      .right_motor_current (rsp_right_motor_current)
   );

endmodule

>>> sv/mtfp_checker.sv
// ----------------------------------------------------------------------------
// mtfp_checker
// Port-level checks for the motor telemetry frame parser.
// ----------------------------------------------------------------------------
module mtfp_checker
   import mtfp_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_full,
   input logic                       rsp_pop,
   input logic                       rsp_empty,
   input logic signed [COUNT_W-1:0]  rsp_left_position,
   input logic signed [COUNT_W-1:0]  rsp_right_position,
   input logic signed [SMALL_W-1:0]  rsp_left_velocity,
   input logic signed [SMALL_W-1:0]  rsp_right_velocity,
   input logic signed [SMALL_W-1:0]  rsp_left_motor_current,
   input logic signed [SMALL_W-1:0]  rsp_right_motor_current
);

   localparam logic [SMALL_W-1:0] SMALL_MIN = {1'b1, {(SMALL_W-1){1'b0}}};

   a_reset_clears : assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("result or full flag left set after reset");

   a_result_holds : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_left_position)
         && $stable(rsp_right_position) && $stable(rsp_left_velocity)
         && $stable(rsp_right_velocity) && $stable(rsp_left_motor_current)
         && $stable(rsp_right_motor_current)))
      else $error("stalled result changed");

   a_small_range : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_left_velocity != SMALL_MIN
         && rsp_right_velocity != SMALL_MIN
         && rsp_left_motor_current != SMALL_MIN
         && rsp_right_motor_current != SMALL_MIN))
      else $error("speed or current outside sign-magnitude range");

   a_no_early_result : assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_empty) |-> !$past(reset))
      else $error("result appeared straight out of reset");

endmodule

bind motor_telemetry_frame_parser mtfp_checker u_mtfp_checker (
   .clock                   (clock),
   .reset                   (reset),
   .req_full                (req_full),
   .rsp_pop                 (rsp_pop),
   .rsp_empty               (rsp_empty),
   .rsp_left_position       (rsp_left_position),
   .rsp_right_position      (rsp_right_position),
   .rsp_left_velocity       (rsp_left_velocity),
   .rsp_right_velocity      (rsp_right_velocity),
   .rsp_left_motor_current  (rsp_left_motor_current),
   .rsp_right_motor_current (rsp_right_motor_current)
);

>>> bench/motor_telemetry_frame_parser_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telemetry frame checker
// Watches the byte and result channels of the frame parser. It decodes each
// accepted request byte with its own parser and queues the telemetry that a
// good frame should give. Each popped result is compared field by field
// with the oldest queued telemetry.
// ----------------------------------------------------------------------------
module motor_telemetry_frame_parser_checker
   import mtfp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  logic                      req_full,
   input  logic [7:0]                req_rx_byte,
   input  logic                      rsp_pop,
   input  logic                      rsp_empty,
   input  logic signed [COUNT_W-1:0] rsp_left_position,
   input  logic signed [COUNT_W-1:0] rsp_right_position,
   input  logic signed [SMALL_W-1:0] rsp_left_velocity,
   input  logic signed [SMALL_W-1:0] rsp_right_velocity,
   input  logic signed [SMALL_W-1:0] rsp_left_motor_current,
   input  logic signed [SMALL_W-1:0] rsp_right_motor_current,
   output int                        fail_count,
   output int                        results_due,
   output int                        results_predicted,
   output int                        results_checked
);

   typedef enum logic [2:0] {
      HUNTING     = 3'b001,
      HEADER_SEEN = 3'b010,
      IN_PAYLOAD  = 3'b100
   } parse_state_type;

   typedef struct packed {
      logic signed [COUNT_W-1:0] left_position;
      logic signed [COUNT_W-1:0] right_position;
      logic signed [SMALL_W-1:0] left_velocity;
      logic signed [SMALL_W-1:0] right_velocity;
      logic signed [SMALL_W-1:0] left_motor_current;
      logic signed [SMALL_W-1:0] right_motor_current;
   } telemetry_type;

   parse_state_type    state;
   logic [INDEX_W-1:0] byte_index;
   logic [7:0]         byte_sum;
   logic [7:0]         payload [SUM_LEN];
   logic [COUNT_W-1:0] left_zero;
   logic [COUNT_W-1:0] right_zero;
   telemetry_type      telemetry_due [$];
   telemetry_type      predicted;
   telemetry_type      oldest;

   task automatic report(input string msg);
      if (fail_count < 100)
         $display("%0t ERROR %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic signed [COUNT_W-1:0] got,
                              input logic signed [COUNT_W-1:0] want);
      if (got !== want)
         report($sformatf("%s: got %0d, expected %0d", name, got, want));
   endtask

   function automatic logic [COUNT_W-1:0] decode_count(input int at);
      logic [COUNT_W-1:0] mag;
      mag = {payload[at+1], payload[at+2], payload[at+3], payload[at+4]};
      return (payload[at] == NEG_SIGN) ? -mag : mag;
   endfunction

   function automatic logic [SMALL_W-1:0] decode_small(input int at);
      logic [SMALL_W-1:0] mag;
      mag = {1'b0, payload[at+1], payload[at+2]};
      return (payload[at] == NEG_SIGN) ? -mag : mag;
   endfunction

   function automatic bit parse_byte(input logic [7:0] b, output telemetry_type t);
      bit                 good;
      logic [COUNT_W-1:0] lc;
      logic [COUNT_W-1:0] rc;
      good = 1'b0;
      t = '0;
      case (state)
         HEADER_SEEN: begin
            if (b == HDR_SECOND)
               state = IN_PAYLOAD;
            else
               state = HUNTING;
            byte_index = '0;
            byte_sum = '0;
         end
         IN_PAYLOAD: begin
            if (byte_index < SUM_LEN) begin
               payload[byte_index] = b;
               byte_sum = byte_sum + b;
               byte_index = byte_index + 1'b1;
            end else begin
               state = HUNTING;
               byte_index = '0;
               good = (byte_sum == b);
               byte_sum = '0;
               if (good) begin
                  lc = decode_count(0);
                  rc = decode_count(5);
                  if (left_zero == '0 && right_zero == '0) begin
                     left_zero = lc;
                     right_zero = rc;
                  end
                  t.left_position       = lc - left_zero;
                  t.right_position      = rc - right_zero;
                  t.left_velocity       = decode_small(10);
                  t.right_velocity      = decode_small(13);
                  t.left_motor_current  = decode_small(16);
                  t.right_motor_current = decode_small(19);
               end
            end
         end
         default: begin
            if (b == HDR_FIRST)
               state = HEADER_SEEN;
            else
               state = HUNTING;
         end
      endcase
      return good;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         state = HUNTING;
         byte_index = '0;
         byte_sum = '0;
         left_zero = '0;
         right_zero = '0;
         telemetry_due.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            results_checked++;
            if (telemetry_due.size() == 0) begin
               report("result popped with no telemetry expected");
            end else begin
               oldest = telemetry_due.pop_front();
               check_field("left_position", rsp_left_position, oldest.left_position);
               check_field("right_position", rsp_right_position, oldest.right_position);
               check_field("left_velocity", rsp_left_velocity, oldest.left_velocity);
               check_field("right_velocity", rsp_right_velocity, oldest.right_velocity);
               check_field("left_motor_current", rsp_left_motor_current,
                           oldest.left_motor_current);
               check_field("right_motor_current", rsp_right_motor_current,
                           oldest.right_motor_current);
            end
         end
         if (req_push && !req_full) begin
            if (parse_byte(req_rx_byte, predicted)) begin
               telemetry_due.push_back(predicted);
               results_predicted++;
            end
         end
      end
      results_due = telemetry_due.size();
   end

endmodule

>>> bench/motor_telemetry_frame_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor telemetry frame parser testbench
// Feeds the parser directed frames (header slips, zero and full-scale
// sign-magnitude values, offset capture, bad checksums) and then a long
// random mix of good frames, corrupt frames, broken headers and line noise,
// with random idle bursts on both channels. A checker module predicts and
// compares the results.
// ----------------------------------------------------------------------------
module motor_telemetry_frame_parser_tb
   import mtfp_pkg::*;
;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_push = 1'b0;
   logic [7:0]                req_rx_byte = 8'h00;
   logic                      rsp_pop = 1'b0;
   logic                      req_full;
   logic                      rsp_empty;
   logic signed [COUNT_W-1:0] rsp_left_position;
   logic signed [COUNT_W-1:0] rsp_right_position;
   logic signed [SMALL_W-1:0] rsp_left_velocity;
   logic signed [SMALL_W-1:0] rsp_right_velocity;
   logic signed [SMALL_W-1:0] rsp_left_motor_current;
   logic signed [SMALL_W-1:0] rsp_right_motor_current;

   int         fail_count;
   int         results_due;
   int         results_predicted;
   int         results_checked;
   int         payload_bytes = 0;
   int         stall_left = 0;
   bit         idling = 1'b1;
   logic [7:0] body [SUM_LEN];

   motor_telemetry_frame_parser dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_push                (req_push),
      .req_full                (req_full),
      .req_rx_byte             (req_rx_byte),
      .rsp_pop                 (rsp_pop),
      .rsp_empty               (rsp_empty),
      .rsp_left_position       (rsp_left_position),
      .rsp_right_position      (rsp_right_position),
      .rsp_left_velocity       (rsp_left_velocity),
      .rsp_right_velocity      (rsp_right_velocity),
      .rsp_left_motor_current  (rsp_left_motor_current),
      .rsp_right_motor_current (rsp_right_motor_current)
   );

   motor_telemetry_frame_parser_checker u_checker (
      .clock                   (clock),
      .reset                   (reset),
      .req_push                (req_push),
      .req_full                (req_full),
      .req_rx_byte             (req_rx_byte),
      .rsp_pop                 (rsp_pop),
      .rsp_empty               (rsp_empty),
      .rsp_left_position       (rsp_left_position),
      .rsp_right_position      (rsp_right_position),
      .rsp_left_velocity       (rsp_left_velocity),
      .rsp_right_velocity      (rsp_right_velocity),
      .rsp_left_motor_current  (rsp_left_motor_current),
      .rsp_right_motor_current (rsp_right_motor_current),
      .fail_count              (fail_count),
      .results_due             (results_due),
      .results_predicted       (results_predicted),
      .results_checked         (results_checked)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_pop <= 1'b0;
      end else if (idling && $urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(0, 17);
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      if (idling && $urandom_range(0, 9) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_full);
   endtask

   task automatic send_frame(input logic [7:0] skew);
      logic [7:0] sum;
      sum = '0;
      send_byte(HDR_FIRST);
      send_byte(HDR_SECOND);
      for (int i = 0; i < SUM_LEN; i++) begin
         sum = sum + body[i];
         send_byte(body[i]);
      end
      send_byte(sum + skew);
      payload_bytes += FRAME_LEN + 2;
   endtask

   // hold the sender until every expected result has been popped
   task automatic drain_results();
      req_push <= 1'b0;
      do @(negedge clock); while (results_due != 0);
      @(posedge clock);
   endtask

   function automatic void put_value(input int at, input logic [7:0] sign,
                                     input logic [31:0] mag, input int nbytes);
      body[at] = sign;
      for (int i = 0; i < nbytes; i++)
         body[at + 1 + i] = mag[8 * (nbytes - 1 - i) +: 8];
   endfunction

   function automatic logic [7:0] pick_sign();
      case ($urandom_range(0, 3))
         0:       return NEG_SIGN;
         1:       return 8'h01;
         2:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_count();
      case ($urandom_range(0, 4))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return $urandom_range(0, 4095);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_small();
      case ($urandom_range(0, 3))
         0:       return 32'h0;
         1:       return 32'hFFFF;
         2:       return 32'h8000;
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   function automatic void randomise_body();
      put_value(0, pick_sign(), pick_count(), 4);
      put_value(5, pick_sign(), pick_count(), 4);
      put_value(10, pick_sign(), pick_small(), 2);
      put_value(13, pick_sign(), pick_small(), 2);
      put_value(16, pick_sign(), pick_small(), 2);
      put_value(19, pick_sign(), pick_small(), 2);
   endfunction

   initial begin
      int         kind;
      logic [7:0] b;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // noise while hunting, then a doubled first header byte
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(HDR_SECOND);
      send_byte(HDR_FIRST);
      send_byte(HDR_FIRST);
      send_byte(HDR_SECOND);

      // zero counts with negative signs: offsets stay clear
      for (int i = 0; i < SUM_LEN; i++)
         body[i] = NEG_SIGN;
      send_frame(8'h00);

      // full-scale values; this frame captures the offsets
      put_value(0, NEG_SIGN, 32'hFFFF_FFFF, 4);
      put_value(5, 8'hFF, 32'h8000_0000, 4);
      put_value(10, NEG_SIGN, 32'hFFFF, 2);
      put_value(13, 8'hFF, 32'hFFFF, 2);
      put_value(16, 8'h01, 32'h0001, 2);
      put_value(19, NEG_SIGN, 32'h8000, 2);
      send_frame(8'h00);

      put_value(0, 8'h01, 32'h7FFF_FFFF, 4);
      put_value(5, NEG_SIGN, 32'h0000_0001, 4);
      send_frame(8'h01);
      send_frame(8'h00);

      // header bytes inside the payload must not resync
      put_value(0, HDR_FIRST, {HDR_SECOND, HDR_FIRST, HDR_SECOND, HDR_FIRST}, 4);
      send_frame(8'h00);

      drain_results();

      while (payload_bytes < 1000) begin
         if (payload_bytes > 850)
            idling = 1'b0;
         kind = $urandom_range(0, 99);
         randomise_body();
         if (kind < 70) begin
            send_frame(8'h00);
         end else if (kind < 80) begin
            send_frame(8'($urandom_range(1, 255)));
         end else if (kind < 87) begin
            b = 8'($urandom);
            if (b == HDR_SECOND)
               b = ~b;
            send_byte(HDR_FIRST);
            send_byte(b);
         end else if (kind < 93) begin
            send_byte(HDR_FIRST);
            send_byte(HDR_SECOND);
            repeat ($urandom_range(1, 21)) begin
               send_byte(8'($urandom));
               payload_bytes++;
            end
         end else begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
         end
      end

      drain_results();
      repeat (4) @(posedge clock);

      $display("Run covered %0d frame bytes plus noise; %0d telemetry results decoded, %0d popped.",
               payload_bytes, results_predicted, results_checked);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
